// ===== hw/rtl/tatg_pkg.sv =====
// Shared types, byte codes and the microcode program of the text terminal.
`timescale 1ns / 1ps

package tatg_pkg;

    localparam int COLUMNS_DEF = 64;
    localparam int ROWS_DEF    = 20;

    localparam int UPC_W = 5;
    typedef logic [UPC_W-1:0] upc_t;

    // Byte codes recognized by the parser, the blank cell code and the clear-all argument.
    localparam logic [7:0] CH_BS       = 8'h08;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_ESC      = 8'h1B;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_NINE     = 8'h39;
    localparam logic [7:0] CH_UPPER_H  = 8'h48;
    localparam logic [7:0] CH_UPPER_J  = 8'h4A;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_TILDE    = 8'h7E;
    localparam logic [6:0] CELL_SPACE  = 7'h20;
    localparam logic [31:0] CLEAR_ALL_ARG = 32'd2;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_ESCAPE = 2'd1,
        MODE_CSI    = 2'd2
    } mode_t;

    // What the latched request asks for, given the parser mode.
    typedef enum logic [3:0] {
        CL_READ,
        CL_ESC,
        CL_BRACKET,
        CL_DIGIT,
        CL_HOME,
        CL_END_SEQ,
        CL_CLEAR,
        CL_CR,
        CL_BS,
        CL_TAB,
        CL_PUT,
        CL_LF,
        CL_IGNORE
    } cls_t;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_ACCEPT,
        OP_EMIT,
        OP_CLR_START,
        OP_CLR_CELL,
        OP_RD_ADDR,
        OP_RD_DATA,
        OP_ESC,
        OP_BRACKET,
        OP_DIGIT,
        OP_HOME,
        OP_END_SEQ,
        OP_CR,
        OP_DEC_COL,
        OP_WR_SPACE,
        OP_PUT_CHAR,
        OP_PUT_SPACE,
        OP_COL_ZERO,
        OP_ROW_INC,
        OP_SCROLL,
        OP_BLANK_CELL
    } op_t;

    typedef enum logic [1:0] {
        J_NEXT,
        J_GOTO,
        J_IF,
        J_MAP
    } jmp_t;

    typedef enum logic [2:0] {
        C_CLR_MORE,
        C_NO_REQ,
        C_OUT_FREE,
        C_COL_ZERO,
        C_TAB_MORE,
        C_COL_OPEN,
        C_ROW_LAST,
        C_BLANK_MORE
    } cond_t;

    typedef struct packed {
        op_t   op;
        jmp_t  jmp;
        cond_t cond;
        upc_t  target;
    } ctrl_t;

    typedef struct packed {
        cls_t cls;
        logic clr_more;
        logic no_req;
        logic out_free;
        logic col_zero;
        logic tab_more;
        logic col_open;
        logic row_last;
        logic blank_more;
    } status_t;

    // Program addresses.
    localparam upc_t A_RST0  = 5'd0;
    localparam upc_t A_RST1  = 5'd1;
    localparam upc_t A_IDLE  = 5'd2;
    localparam upc_t A_DISP  = 5'd3;
    localparam upc_t A_EMIT  = 5'd4;
    localparam upc_t A_EMITW = 5'd5;
    localparam upc_t A_RD0   = 5'd6;
    localparam upc_t A_RD1   = 5'd7;
    localparam upc_t A_ESC   = 5'd8;
    localparam upc_t A_BRK   = 5'd9;
    localparam upc_t A_DIG   = 5'd10;
    localparam upc_t A_HOME  = 5'd11;
    localparam upc_t A_ENDS  = 5'd12;
    localparam upc_t A_CR    = 5'd13;
    localparam upc_t A_BS0   = 5'd14;
    localparam upc_t A_BS1   = 5'd15;
    localparam upc_t A_BS2   = 5'd16;
    localparam upc_t A_PUT   = 5'd17;
    localparam upc_t A_TAB   = 5'd18;
    localparam upc_t A_ADV   = 5'd19;
    localparam upc_t A_LF0   = 5'd20;
    localparam upc_t A_LFINC = 5'd21;
    localparam upc_t A_SCRL  = 5'd22;
    localparam upc_t A_BLNK  = 5'd23;
    localparam upc_t A_BLNKX = 5'd24;
    localparam upc_t A_CLR0  = 5'd25;
    localparam upc_t A_CLR1  = 5'd26;
    localparam upc_t A_CLRX  = 5'd27;

    function automatic ctrl_t ucode(upc_t a);
        ctrl_t c;
        case (a)
            A_RST0:  c = '{OP_CLR_START,  J_NEXT, C_CLR_MORE,   A_RST0};
            A_RST1:  c = '{OP_CLR_CELL,   J_IF,   C_CLR_MORE,   A_RST1};
            A_IDLE:  c = '{OP_ACCEPT,     J_IF,   C_NO_REQ,     A_IDLE};
            A_DISP:  c = '{OP_NOP,        J_MAP,  C_NO_REQ,     A_IDLE};
            A_EMIT:  c = '{OP_EMIT,       J_IF,   C_OUT_FREE,   A_IDLE};
            A_EMITW: c = '{OP_NOP,        J_GOTO, C_OUT_FREE,   A_EMIT};
            A_RD0:   c = '{OP_RD_ADDR,    J_NEXT, C_NO_REQ,     A_IDLE};
            A_RD1:   c = '{OP_RD_DATA,    J_GOTO, C_NO_REQ,     A_EMIT};
            A_ESC:   c = '{OP_ESC,        J_GOTO, C_NO_REQ,     A_EMIT};
            A_BRK:   c = '{OP_BRACKET,    J_GOTO, C_NO_REQ,     A_EMIT};
            A_DIG:   c = '{OP_DIGIT,      J_GOTO, C_NO_REQ,     A_EMIT};
            A_HOME:  c = '{OP_HOME,       J_GOTO, C_NO_REQ,     A_EMIT};
            A_ENDS:  c = '{OP_END_SEQ,    J_GOTO, C_NO_REQ,     A_EMIT};
            A_CR:    c = '{OP_CR,         J_GOTO, C_NO_REQ,     A_EMIT};
            A_BS0:   c = '{OP_NOP,        J_IF,   C_COL_ZERO,   A_EMIT};
            A_BS1:   c = '{OP_DEC_COL,    J_NEXT, C_NO_REQ,     A_IDLE};
            A_BS2:   c = '{OP_WR_SPACE,   J_GOTO, C_NO_REQ,     A_EMIT};
            A_PUT:   c = '{OP_PUT_CHAR,   J_GOTO, C_NO_REQ,     A_ADV};
            A_TAB:   c = '{OP_PUT_SPACE,  J_IF,   C_TAB_MORE,   A_TAB};
            A_ADV:   c = '{OP_NOP,        J_IF,   C_COL_OPEN,   A_EMIT};
            A_LF0:   c = '{OP_COL_ZERO,   J_IF,   C_ROW_LAST,   A_SCRL};
            A_LFINC: c = '{OP_ROW_INC,    J_GOTO, C_NO_REQ,     A_EMIT};
            A_SCRL:  c = '{OP_SCROLL,     J_NEXT, C_NO_REQ,     A_IDLE};
            A_BLNK:  c = '{OP_BLANK_CELL, J_IF,   C_BLANK_MORE, A_BLNK};
            A_BLNKX: c = '{OP_NOP,        J_GOTO, C_NO_REQ,     A_EMIT};
            A_CLR0:  c = '{OP_CLR_START,  J_NEXT, C_NO_REQ,     A_IDLE};
            A_CLR1:  c = '{OP_CLR_CELL,   J_IF,   C_CLR_MORE,   A_CLR1};
            A_CLRX:  c = '{OP_NOP,        J_GOTO, C_NO_REQ,     A_EMIT};
            default: c = '{OP_NOP,        J_GOTO, C_NO_REQ,     A_IDLE};
        endcase
        return c;
    endfunction

    // Entry point of the routine that serves each kind of request.
    function automatic upc_t dispatch(cls_t k);
        upc_t a;
        case (k)
            CL_READ:    a = A_RD0;
            CL_ESC:     a = A_ESC;
            CL_BRACKET: a = A_BRK;
            CL_DIGIT:   a = A_DIG;
            CL_HOME:    a = A_HOME;
            CL_END_SEQ: a = A_ENDS;
            CL_CLEAR:   a = A_CLR0;
            CL_CR:      a = A_CR;
            CL_BS:      a = A_BS0;
            CL_TAB:     a = A_TAB;
            CL_PUT:     a = A_PUT;
            CL_LF:      a = A_LF0;
            default:    a = A_EMIT;
        endcase
        return a;
    endfunction

endpackage

// ===== hw/rtl/tatg_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module tatg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hw/rtl/tatg_useq.sv =====
// Microprogram sequencer: step counter, control store and jump logic.
`timescale 1ns / 1ps

module tatg_useq
    import tatg_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  status_t status,
    output ctrl_t   ctrl
);

    upc_t upc_reg;
    upc_t upc_next;
    logic hit;

    assign ctrl = ucode(upc_reg);

    always_comb
    begin
        case (ctrl.cond)
            C_CLR_MORE:   hit = status.clr_more;
            C_NO_REQ:     hit = status.no_req;
            C_OUT_FREE:   hit = status.out_free;
            C_COL_ZERO:   hit = status.col_zero;
            C_TAB_MORE:   hit = status.tab_more;
            C_COL_OPEN:   hit = status.col_open;
            C_ROW_LAST:   hit = status.row_last;
            C_BLANK_MORE: hit = status.blank_more;
            default:      hit = 1'b0;
        endcase
    end

    always_comb
    begin
        case (ctrl.jmp)
            J_NEXT:  upc_next = upc_reg + 1'b1;
            J_GOTO:  upc_next = ctrl.target;
            J_IF:    upc_next = hit ? ctrl.target : upc_reg + 1'b1;
            J_MAP:   upc_next = dispatch(status.cls);
            default: upc_next = A_IDLE;
        endcase
    end

    // Reset starts the program at the grid clearing pass.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= A_RST0;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

endmodule

// ===== hw/rtl/tatg_dpath.sv =====
// Terminal datapath: cursor, parser state, row mapping, grid memory and output register.
`timescale 1ns / 1ps

module tatg_dpath
    import tatg_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int ROWS    = ROWS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  ctrl_t       ctrl,
    output status_t     status,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,
    input  logic [0:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata
);

    localparam int CW    = $clog2(COLUMNS);
    localparam int CW1   = $clog2(COLUMNS + 1);
    localparam int RW    = $clog2(ROWS);
    localparam int AW    = RW + CW;
    localparam int DEPTH = ROWS * (2 ** CW);
    localparam logic [CW-1:0]  COL_LAST = CW'(COLUMNS - 1);
    localparam logic [CW1-1:0] COL_END  = CW1'(COLUMNS);
    localparam logic [RW-1:0]  ROW_LAST = RW'(ROWS - 1);
    localparam logic [RW:0]    ROW_NUM  = (RW + 1)'(ROWS);

    logic [RW-1:0]  cur_row_reg, cur_row_next;
    logic [CW1-1:0] cur_col_reg, cur_col_next;
    mode_t          mode_reg, mode_next;
    logic [31:0]    seq_reg, seq_next;
    logic           has_digit_reg, has_digit_next;
    logic [RW-1:0]  top_reg, top_next;
    logic [RW-1:0]  sw_row_reg, sw_row_next;
    logic [CW-1:0]  sw_col_reg, sw_col_next;
    logic           cmd_reg, cmd_next;
    logic [7:0]     byte_reg, byte_next;
    logic [4:0]     rrow_reg, rrow_next;
    logic [5:0]     rcol_reg, rcol_next;
    logic [6:0]     cell_reg, cell_next;
    logic           out_valid_reg;
    logic [23:0]    out_data_reg;

    logic           out_free;
    logic           emit_load;
    logic           rd_ok;
    logic [RW-1:0]  rd_lrow;
    logic [CW-1:0]  rd_col;
    logic [CW1-1:0] col_p1;
    logic [RW-1:0]  lrow;
    logic [CW-1:0]  acol;
    logic [RW:0]    row_sum;
    logic [RW-1:0]  prow;
    logic           mem_we;
    logic           mem_re;
    logic [6:0]     mem_wdata;
    logic [6:0]     mem_rdata;
    logic [AW-1:0]  mem_addr;
    cls_t           cls;

    assign s_axis_tready = (ctrl.op == OP_ACCEPT);
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign emit_load     = (ctrl.op == OP_EMIT) && out_free;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign rd_ok   = (int'(rrow_reg) < ROWS) && (int'(rcol_reg) < COLUMNS);
    assign rd_lrow = rd_ok ? RW'(rrow_reg) : '0;
    assign rd_col  = rd_ok ? CW'(rcol_reg) : '0;
    assign col_p1  = cur_col_reg + 1'b1;

    // The grid scrolls by moving the top row pointer; logical rows map onto
    // physical rows modulo ROWS.
    assign row_sum  = {1'b0, lrow} + {1'b0, top_reg};
    assign prow     = (row_sum >= ROW_NUM) ? RW'(row_sum - ROW_NUM) : row_sum[RW-1:0];
    assign mem_addr = {prow, acol};

    always_comb
    begin
        cls = CL_IGNORE;
        if (cmd_reg)
        begin
            cls = CL_READ;
        end
        else
        begin
            case (mode_reg)
                MODE_ESCAPE:
                begin
                    cls = CL_BRACKET;
                end
                MODE_CSI:
                begin
                    if (byte_reg inside {[CH_ZERO:CH_NINE]})
                    begin
                        cls = CL_DIGIT;
                    end
                    else if (byte_reg == CH_UPPER_J)
                    begin
                        cls = (!has_digit_reg || seq_reg == CLEAR_ALL_ARG) ? CL_CLEAR
                                                                             : CL_END_SEQ;
                    end
                    else if (byte_reg == CH_UPPER_H)
                    begin
                        cls = CL_HOME;
                    end
                    else
                    begin
                        cls = CL_END_SEQ;
                    end
                end
                default:
                begin
                    case (byte_reg)
                        CH_ESC:  cls = CL_ESC;
                        CH_LF:   cls = CL_LF;
                        CH_CR:   cls = CL_CR;
                        CH_BS:   cls = CL_BS;
                        CH_TAB:  cls = CL_TAB;
                        default: cls = (byte_reg inside {[CH_SPACE:CH_TILDE]}) ? CL_PUT
                                                                                : CL_IGNORE;
                    endcase
                end
            endcase
        end
    end

    always_comb
    begin
        status.cls        = cls;
        status.clr_more   = !((sw_row_reg == ROW_LAST) && (sw_col_reg == COL_LAST));
        status.no_req     = !s_axis_tvalid;
        status.out_free   = out_free;
        status.col_zero   = (cur_col_reg == '0);
        status.tab_more   = (col_p1[2:0] != 3'd0) && (col_p1 < COL_END);
        status.col_open   = (cur_col_reg < COL_END);
        status.row_last   = (cur_row_reg == ROW_LAST);
        status.blank_more = (sw_col_reg != COL_LAST);
    end

    always_comb
    begin
        cur_row_next   = cur_row_reg;
        cur_col_next   = cur_col_reg;
        mode_next      = mode_reg;
        seq_next       = seq_reg;
        has_digit_next = has_digit_reg;
        top_next       = top_reg;
        sw_row_next    = sw_row_reg;
        sw_col_next    = sw_col_reg;
        cmd_next       = cmd_reg;
        byte_next      = byte_reg;
        rrow_next      = rrow_reg;
        rcol_next      = rcol_reg;
        cell_next      = cell_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_wdata      = CELL_SPACE;
        lrow           = cur_row_reg;
        acol           = cur_col_reg[CW-1:0];
        case (ctrl.op)
            OP_ACCEPT:
            begin
                if (s_axis_tvalid)
                begin
                    cmd_next  = s_axis_tuser[0];
                    byte_next = s_axis_tdata[7:0];
                    rrow_next = s_axis_tdata[12:8];
                    rcol_next = s_axis_tdata[18:13];
                    cell_next = '0;
                end
            end
            OP_CLR_START:
            begin
                top_next     = '0;
                cur_row_next = '0;
                cur_col_next = '0;
                sw_row_next  = '0;
                sw_col_next  = '0;
                mode_next    = MODE_NORMAL;
            end
            OP_CLR_CELL:
            begin
                mem_we = 1'b1;
                lrow   = sw_row_reg;
                acol   = sw_col_reg;
                if (sw_col_reg == COL_LAST)
                begin
                    sw_col_next = '0;
                    sw_row_next = sw_row_reg + 1'b1;
                end
                else
                begin
                    sw_col_next = sw_col_reg + 1'b1;
                end
            end
            OP_RD_ADDR:
            begin
                mem_re = 1'b1;
                lrow   = rd_lrow;
                acol   = rd_col;
            end
            OP_RD_DATA:
            begin
                cell_next = rd_ok ? mem_rdata : CELL_SPACE;
            end
            OP_ESC:
            begin
                mode_next = MODE_ESCAPE;
            end
            OP_BRACKET:
            begin
                if (byte_reg == CH_LBRACKET)
                begin
                    mode_next      = MODE_CSI;
                    seq_next       = '0;
                    has_digit_next = 1'b0;
                end
                else
                begin
                    mode_next = MODE_NORMAL;
                end
            end
            OP_DIGIT:
            begin
                // Times ten as two shifted adds, wrapping at 32 bits.
                seq_next       = (seq_reg << 3) + (seq_reg << 1) + {28'd0, byte_reg[3:0]};
                has_digit_next = 1'b1;
            end
            OP_HOME:
            begin
                cur_row_next = '0;
                cur_col_next = '0;
                mode_next    = MODE_NORMAL;
            end
            OP_END_SEQ:
            begin
                mode_next = MODE_NORMAL;
            end
            OP_CR, OP_COL_ZERO:
            begin
                cur_col_next = '0;
            end
            OP_DEC_COL:
            begin
                cur_col_next = cur_col_reg - 1'b1;
            end
            OP_WR_SPACE:
            begin
                mem_we = 1'b1;
            end
            OP_PUT_CHAR:
            begin
                mem_we       = 1'b1;
                mem_wdata    = byte_reg[6:0];
                cur_col_next = col_p1;
            end
            OP_PUT_SPACE:
            begin
                mem_we       = 1'b1;
                cur_col_next = col_p1;
            end
            OP_ROW_INC:
            begin
                cur_row_next = cur_row_reg + 1'b1;
            end
            OP_SCROLL:
            begin
                top_next    = (top_reg == ROW_LAST) ? '0 : top_reg + 1'b1;
                sw_col_next = '0;
            end
            OP_BLANK_CELL:
            begin
                mem_we      = 1'b1;
                lrow        = ROW_LAST;
                acol        = sw_col_reg;
                sw_col_next = sw_col_reg + 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_row_reg   <= '0;
            cur_col_reg   <= '0;
            mode_reg      <= MODE_NORMAL;
            seq_reg       <= '0;
            has_digit_reg <= 1'b0;
            top_reg       <= '0;
            sw_row_reg    <= '0;
            sw_col_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_row_reg   <= cur_row_next;
            cur_col_reg   <= cur_col_next;
            mode_reg      <= mode_next;
            seq_reg       <= seq_next;
            has_digit_reg <= has_digit_next;
            top_reg       <= top_next;
            sw_row_reg    <= sw_row_next;
            sw_col_reg    <= sw_col_next;
            if (emit_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        byte_reg <= byte_next;
        rrow_reg <= rrow_next;
        rcol_reg <= rcol_next;
        cell_reg <= cell_next;
        if (emit_load)
        begin
            out_data_reg <= {4'd0, mode_reg, 6'(cur_col_reg), 5'(cur_row_reg), cell_reg};
        end
    end

    tatg_ram #(
        .WIDTH (7),
        .DEPTH (DEPTH)
    ) u_grid (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_addr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_addr),
        .rdata (mem_rdata)
    );

endmodule

// ===== hw/rtl/ansi_text_terminal_grid.sv =====
// Top level of the character terminal grid: sequencer plus datapath.
`timescale 1ns / 1ps
//
//  Channel  Direction  Handshake                    Payload
//  s_axis   in         s_axis_tvalid/s_axis_tready  tdata: char_code, read_row, read_col
//                                                   tuser: command
//  m_axis   out        m_axis_tvalid/m_axis_tready  tdata: cell_char, cursor_row,
//                                                   cursor_col, parse_mode
//
//  Reset starts a clearing pass over every cell of the grid that takes no request.
//  Each request runs the routine for its kind: a control or sequence byte, a read, a
//  printable byte or a tab, which writes spaces up to the next tab stop; one control word per cycle.
//  Wrapping to a new line runs the newline routine; a scroll at the last row also blanks
//  the new last row, cell by cell. ESC [ J or ESC [ 2 J clears the whole grid.
//  A waiting result holds the next request at its final step.

module ansi_text_terminal_grid
    import tatg_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int ROWS    = ROWS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // char_code[7:0], read_row[12:8], read_col[18:13]
    input  logic [0:0]  s_axis_tuser,  // command[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata   // cell_char[6:0], cursor_row[11:7],
                                       // cursor_col[17:12], parse_mode[19:18]
);

    ctrl_t   ctrl;
    status_t status;

    tatg_useq u_useq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    tatg_dpath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .status        (status),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

`ifndef SYNTHESIS
    // Only one request is taken per pass through the program.
    a_single_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request accepted on two consecutive cycles");

    // A result step with a free output register must present the result.
    a_emit_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == OP_EMIT) && status.out_free |=> m_axis_tvalid)
        else $error("result step did not load the output register");

    // The reported cursor always lies inside the grid.
    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[17:12] < COLUMNS) && (m_axis_tdata[11:7] < ROWS))
        else $error("cursor outside the grid in a result");
`endif

endmodule
